### rtl/wsd_pkg.sv
package wsd_pkg;

   localparam int ByteWidth   = 8;
   localparam int OpcodeWidth = 4;
   localparam int LengthWidth = 64;
   localparam int KeyWidth    = 32;
   localparam int CountWidth  = 3;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [OpcodeWidth-1:0] opcode_type;
   typedef logic [LengthWidth-1:0] length_type;
   typedef logic [KeyWidth-1:0]    key_type;
   typedef logic [CountWidth-1:0]  count_type;

   // result_kind codes
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // 7-bit length escapes
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // extended length / mask key bytes still to come, minus one
   localparam count_type EXT16_COUNT = 3'd1;
   localparam count_type EXT64_COUNT = 3'd7;
   localparam count_type KEY_COUNT   = 3'd3;

endpackage

### rtl/wsd_req_if.sv
interface wsd_req_if import wsd_pkg::*; ();

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

### rtl/wsd_rsp_if.sv
interface wsd_rsp_if import wsd_pkg::*; ();

   logic       valid;
   logic       ready;
   logic       result_kind;
   opcode_type frame_opcode;
   logic       fin_flag;
   logic       mask_flag;
   length_type frame_length;
   byte_type   payload_data;
   logic       last_byte;

   modport source (output valid, output result_kind, output frame_opcode, output fin_flag,
                   output mask_flag, output frame_length, output payload_data,
                   output last_byte, input ready);
   modport sink   (input valid, input result_kind, input frame_opcode, input fin_flag,
                   input mask_flag, input frame_length, input payload_data,
                   input last_byte, output ready);

endinterface

### rtl/websocket_frame_deframer.sv
// Channel   Dir  Payload
// req_ch    in   rx_byte: one stream byte per word
// rsp_ch    out  result_kind, frame_opcode, fin_flag, mask_flag, frame_length,
//                payload_data, last_byte
//
// One byte per clock sustained while rsp_ch is ready; results are registered at the output.
// The parser runs once per byte between the input register and the result register.
// Synchronous active-high reset returns the parser to the first header byte.
// A stalled result holds the parser; the input register still takes one more byte.
module websocket_frame_deframer import wsd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_ch,
   wsd_rsp_if.source rsp_ch
);

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD
   } phase_type;

   // input register
   logic       in_valid_ff;
   byte_type   in_byte_ff;

   // parser state
   phase_type  phase_ff, phase_in;
   opcode_type opcode_ff, opcode_in;
   logic       fin_ff, fin_in;
   logic       masked_ff, masked_in;
   count_type  count_ff, count_in;
   length_type total_ff, total_in;
   key_type    key_ff, key_in;
   length_type seen_ff, seen_in;

   // result register
   logic       rsp_valid_ff;
   logic       kind_ff;
   opcode_type rsp_opcode_ff;
   logic       rsp_fin_ff;
   logic       rsp_mask_ff;
   length_type rsp_length_ff;
   byte_type   rsp_data_ff;
   logic       rsp_last_ff;

   logic       out_free;
   logic       advance;
   logic       emit;
   logic       emit_kind;
   byte_type   emit_data;
   logic       emit_last;
   logic       len_done;
   logic       hdr_done;
   logic [6:0] len7;
   byte_type   key_byte;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   assign len7     = in_byte_ff[6:0];
   assign key_byte = key_ff[(KeyWidth - 1 - ByteWidth * seen_ff[1:0]) -: ByteWidth];

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      key_in    = key_ff;
      seen_in   = seen_ff;
      emit      = 1'b0;
      emit_kind = KIND_HEADER;
      emit_data = '0;
      emit_last = 1'b0;
      len_done  = 1'b0;
      hdr_done  = 1'b0;

      unique case (phase_ff)
         PH_SECOND: begin
            masked_in = in_byte_ff[7];
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
               total_in = '0;
               count_in = (len7 == LEN_EXT16) ? EXT16_COUNT : EXT64_COUNT;
               phase_in = PH_EXTLEN;
            end else begin
               total_in = {{(LengthWidth - 7){1'b0}}, len7};
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            total_in = {total_ff[LengthWidth-ByteWidth-1:0], in_byte_ff};
            if (count_ff == '0) begin
               len_done = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         PH_MASK: begin
            key_in = {key_ff[KeyWidth-ByteWidth-1:0], in_byte_ff};
            if (count_ff == '0) begin
               hdr_done = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         PH_PAYLOAD: begin
            emit_data = masked_ff ? (in_byte_ff ^ key_byte) : in_byte_ff;
            seen_in   = seen_ff + 1'b1;
            emit_last = (seen_in >= total_ff);
            if (emit_last) begin
               phase_in = PH_FIRST;
            end
            emit      = 1'b1;
            emit_kind = KIND_PAYLOAD;
         end
         default: begin
            fin_in    = in_byte_ff[7];
            opcode_in = in_byte_ff[OpcodeWidth-1:0];
            phase_in  = PH_SECOND;
         end
      endcase

      // length known: collect the mask key or close the header
      if (len_done) begin
         if (masked_in) begin
            key_in   = '0;
            count_in = KEY_COUNT;
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end

      if (hdr_done) begin
         seen_in   = '0;
         count_in  = '0;
         phase_in  = (total_in == '0) ? PH_FIRST : PH_PAYLOAD;
         emit      = 1'b1;
         emit_kind = KIND_HEADER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FIRST;
         opcode_ff    <= '0;
         fin_ff       <= 1'b0;
         masked_ff    <= 1'b0;
         count_ff     <= '0;
         total_ff     <= '0;
         key_ff       <= '0;
         seen_ff      <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_ch.rx_byte;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            phase_ff  <= phase_in;
            opcode_ff <= opcode_in;
            fin_ff    <= fin_in;
            masked_ff <= masked_in;
            count_ff  <= count_in;
            total_ff  <= total_in;
            key_ff    <= key_in;
            seen_ff   <= seen_in;
         end

         if (out_free) begin
            rsp_valid_ff <= advance && emit;
         end

         if (advance && emit) begin
            kind_ff       <= emit_kind;
            rsp_opcode_ff <= opcode_in;
            rsp_fin_ff    <= fin_in;
            rsp_mask_ff   <= masked_in;
            rsp_length_ff <= total_in;
            rsp_data_ff   <= emit_data;
            rsp_last_ff   <= emit_last;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = kind_ff;
   assign rsp_ch.frame_opcode = rsp_opcode_ff;
   assign rsp_ch.fin_flag     = rsp_fin_ff;
   assign rsp_ch.mask_flag    = rsp_mask_ff;
   assign rsp_ch.frame_length = rsp_length_ff;
   assign rsp_ch.payload_data = rsp_data_ff;
   assign rsp_ch.last_byte    = rsp_last_ff;

endmodule
